// ===== rtl/kda_pkg.sv =====
// kda_pkg: shared types, register map and limits for the keypad debounce block
// no dependencies
package kda_pkg;

	localparam int MAX_ROWS = 4;
	localparam int MAX_COLUMNS = 4;
	localparam int TIMER_BITS = 16;

	localparam int MATRIX_W = 16;
	localparam int KEY_W = 4;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_ROWS = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COLUMNS = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_FIRST_HOLD = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_NEXT_HOLD = 3'd4;

	typedef struct packed {
		logic [2:0]  rows_in_use;
		logic [2:0]  columns_in_use;
		logic [7:0]  debounce_ticks;
		logic [15:0] first_hold_ticks;
		logic [15:0] next_hold_ticks;
	} cfg_t;

	typedef enum logic [4:0] {
		M_IDLE        = 5'b00001,
		M_DEB_PRESS   = 5'b00010,
		M_DEB_RELEASE = 5'b00100,
		M_FIRST_HOLD  = 5'b01000,
		M_NEXT_HOLD   = 5'b10000
	} mode_t;

	typedef struct packed {
		logic             pressed;
		logic [KEY_W-1:0] key;
	} pick_t;

endpackage

// ===== rtl/kda_cfg.sv =====
// kda_cfg: apb register file holding the scan and timing settings
// depends on kda_pkg
module kda_cfg
	import kda_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic wr;

	assign idx = paddr[ADDR_W-1:2];
	assign wr = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rows_in_use <= 3'd4;
			cfg_q.columns_in_use <= 3'd4;
			cfg_q.debounce_ticks <= 8'd2;
			cfg_q.first_hold_ticks <= 16'd50;
			cfg_q.next_hold_ticks <= 16'd10;
		end else if (wr) begin
			unique case (idx)
				REG_ROWS:       cfg_q.rows_in_use <= pwdata[2:0];
				REG_COLUMNS:    cfg_q.columns_in_use <= pwdata[2:0];
				REG_DEBOUNCE:   cfg_q.debounce_ticks <= pwdata[7:0];
				REG_FIRST_HOLD: cfg_q.first_hold_ticks <= pwdata[15:0];
				REG_NEXT_HOLD:  cfg_q.next_hold_ticks <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ROWS:       prdata = {29'd0, cfg_q.rows_in_use};
			REG_COLUMNS:    prdata = {29'd0, cfg_q.columns_in_use};
			REG_DEBOUNCE:   prdata = {24'd0, cfg_q.debounce_ticks};
			REG_FIRST_HOLD: prdata = {16'd0, cfg_q.first_hold_ticks};
			REG_NEXT_HOLD:  prdata = {16'd0, cfg_q.next_hold_ticks};
			default:        prdata = '0;
		endcase
	end

endmodule

// ===== rtl/kda_pick.sv =====
// kda_pick: priority key pick over the rows and columns in use
// depends on kda_pkg
module kda_pick
	import kda_pkg::*;
(
	input  logic [MATRIX_W-1:0] matrix,
	input  cfg_t                cfg,
	output pick_t               pick
);

	logic [3:0] nr;
	logic [3:0] nc;

	always_comb begin
		nr = (int'(cfg.rows_in_use) > MAX_ROWS) ? 4'(MAX_ROWS) : {1'b0, cfg.rows_in_use};
		nc = (int'(cfg.columns_in_use) > MAX_COLUMNS) ?
			4'(MAX_COLUMNS) : {1'b0, cfg.columns_in_use};
	end

	// lowest row first, then lowest column
	always_comb begin
		pick.pressed = 1'b0;
		pick.key = '0;
		for (int r = 0; r < MAX_ROWS; r++) begin
			for (int c = 0; c < MAX_COLUMNS; c++) begin
				if (r * MAX_COLUMNS + c < MATRIX_W) begin
					if (!pick.pressed && (r < int'(nr)) && (c < int'(nc)) &&
					    matrix[r * MAX_COLUMNS + c]) begin
						pick.pressed = 1'b1;
						pick.key = 4'(4'(r) * nc) + 4'(c);
					end
				end
			end
		end
	end

endmodule

// ===== rtl/kda_fsm.sv =====
// kda_fsm: debounce and repeat state machine, tick timer and result register
// depends on kda_pkg
module kda_fsm
	import kda_pkg::*;
#(
	parameter int TIMER_BITS = kda_pkg::TIMER_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tick,
	input  pick_t            pick,
	input  cfg_t             cfg,
	input  logic             event_ready,
	output logic             event_valid,
	output logic [KEY_W-1:0] key_index,
	output logic             repeat_event
);

	localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

	mode_t mode_q, mode_d;
	logic [KEY_W-1:0] last_key_q, last_key_d;
	logic [TIMER_BITS-1:0] elapsed_q, elapsed_d, elapsed_inc;
	logic valid_q;
	logic [KEY_W-1:0] key_q;
	logic rep_q;
	logic emit, emit_rep;
	logic [CMP_W-1:0] el_x, hold_x;

	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
	assign el_x = CMP_W'(elapsed_inc);
	assign hold_x = (mode_q == M_FIRST_HOLD) ? CMP_W'(cfg.first_hold_ticks) :
		CMP_W'(cfg.next_hold_ticks);

	always_comb begin
		mode_d = mode_q;
		last_key_d = last_key_q;
		elapsed_d = elapsed_inc;
		emit = 1'b0;
		emit_rep = 1'b0;
		unique case (mode_q)
			M_DEB_PRESS: begin
				if (!pick.pressed) begin
					elapsed_d = '0;
					mode_d = M_DEB_RELEASE;
				end else if (pick.key != last_key_q) begin
					last_key_d = pick.key;
					elapsed_d = '0;
				end else if (el_x >= CMP_W'(cfg.debounce_ticks)) begin
					emit = 1'b1;
					elapsed_d = '0;
					mode_d = M_FIRST_HOLD;
				end
			end
			M_DEB_RELEASE: begin
				if (el_x >= CMP_W'(cfg.debounce_ticks)) begin
					if (!pick.pressed) begin
						mode_d = M_IDLE;
					end else begin
						last_key_d = pick.key;
						elapsed_d = '0;
						mode_d = M_DEB_PRESS;
					end
				end
			end
			M_FIRST_HOLD, M_NEXT_HOLD: begin
				if (!pick.pressed) begin
					elapsed_d = '0;
					mode_d = M_DEB_RELEASE;
				end else if (pick.key != last_key_q) begin
					last_key_d = pick.key;
					elapsed_d = '0;
					mode_d = M_DEB_PRESS;
				end else if (el_x >= hold_x) begin
					emit = 1'b1;
					emit_rep = 1'b1;
					elapsed_d = '0;
					mode_d = M_NEXT_HOLD;
				end
			end
			default: begin
				if (pick.pressed) begin
					last_key_d = pick.key;
					elapsed_d = '0;
					mode_d = M_DEB_PRESS;
				end else begin
					mode_d = M_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			last_key_q <= '0;
			elapsed_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (tick) begin
				mode_q <= mode_d;
				last_key_q <= last_key_d;
				elapsed_q <= elapsed_d;
				valid_q <= emit;
			end else if (event_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick && emit) begin
			key_q <= pick.key;
			rep_q <= emit_rep;
		end
	end

	assign event_valid = valid_q;
	assign key_index = key_q;
	assign repeat_event = rep_q;

endmodule

// ===== rtl/keypad_debounce_autorepeat.sv =====
// keypad_debounce_autorepeat: matrix keypad scanner with debounce and typematic repeat
// flow: an accepted matrix is registered in stage 1; its event is registered when stage 1 ticks
// one tick per cycle unless stalled; the tick and event registers share one stall
// reset: settings return to 4 rows, 4 columns, debounce 2, holds 50 and 10; state idle
// depends on kda_pkg, kda_cfg, kda_pick, kda_fsm
module keypad_debounce_autorepeat
	import kda_pkg::*;
#(
	parameter int TIMER_BITS = kda_pkg::TIMER_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic [MATRIX_W-1:0] pressed_matrix,
	output logic                event_valid,
	input  logic                event_ready,
	output logic [KEY_W-1:0]    key_index,
	output logic                repeat_event
);

	cfg_t cfg;
	pick_t pick;
	logic valid_s1;
	logic [MATRIX_W-1:0] matrix_s1;
	logic adv;

	assign adv = valid_s1 & (~event_valid | event_ready);
	assign item_ready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			matrix_s1 <= pressed_matrix;
		end
	end

	kda_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	kda_pick u_pick (
		.matrix (matrix_s1),
		.cfg    (cfg),
		.pick   (pick)
	);

	kda_fsm #(
		.TIMER_BITS (TIMER_BITS)
	) u_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick         (adv),
		.pick         (pick),
		.cfg          (cfg),
		.event_ready  (event_ready),
		.event_valid  (event_valid),
		.key_index    (key_index),
		.repeat_event (repeat_event)
	);

endmodule
